@@ hdl/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 (BMP) decoder.
// No dependencies; used by the step logic, the top level and the checker.
package u8u16_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned UnitW   = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned PartW   = 10;

  localparam logic [CountW-1:0] MaxUnitsReset = 16'd1024;
  localparam logic [UnitW-1:0]  SurrLo        = 16'hD800;
  localparam logic [UnitW-1:0]  SurrHi        = 16'hDFFF;

  // Decode phase: how many continuation bytes are still owed.
  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_e;

  // Status codes reported on the end-of-string result.
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_SURROGATE = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_e;

  typedef struct packed {
    phase_e             phase;
    logic [PartW-1:0]   partial;
    logic [CountW-1:0]  units;
    err_e               err;
  } dec_state_t;

  typedef struct packed {
    logic               valid;
    logic [UnitW-1:0]   code_unit;
    logic               unit_valid;
    logic               done_res;
    err_e               status;
    logic [CountW-1:0]  unit_count;
  } dec_result_t;

endpackage

@@ hdl/u8u16_step.sv @@
// Per-byte decode step: next string state and the optional result for one byte.
// Purely combinational; depends on u8u16_pkg.
module u8u16_step
  import u8u16_pkg::*;
(
  input  logic [ByteW-1:0]  byte_i,
  input  dec_state_t        state_i,
  input  logic [CountW-1:0] unit_limit_i,
  output dec_state_t        state_o,
  output dec_result_t       result_o
);

  logic [UnitW-1:0] cp;
  logic             is_cont;

  assign is_cont = (byte_i[7:6] == 2'b10);
  assign cp      = {state_i.partial, byte_i[5:0]};

  always_comb begin
    state_o  = state_i;
    result_o = '0;

    if (byte_i == '0) begin
      // Terminator: report and clear the string state.
      result_o.valid      = 1'b1;
      result_o.done_res   = 1'b1;
      result_o.unit_count = state_i.units;
      if (state_i.err == ERR_NONE && state_i.phase != PH_LEAD) begin
        result_o.status = ERR_MALFORMED;
      end else begin
        result_o.status = state_i.err;
      end
      state_o = '{phase: PH_LEAD, partial: '0, units: '0, err: ERR_NONE};
    end else if (state_i.err != ERR_NONE) begin
      // Swallow until the terminator.
      state_o = state_i;
    end else if (state_i.phase == PH_LEAD) begin
      if (state_i.units >= unit_limit_i) begin
        state_o.err = ERR_OVERFLOW;
      end else if (byte_i[7] == 1'b0) begin
        result_o.valid      = 1'b1;
        result_o.unit_valid = 1'b1;
        result_o.code_unit  = {8'd0, byte_i};
        state_o.units       = state_i.units + CountW'(1);
      end else if (byte_i[7:5] == 3'b110) begin
        state_o.partial = {5'd0, byte_i[4:0]};
        state_o.phase   = PH_ONE;
      end else if (byte_i[7:4] == 4'b1110) begin
        state_o.partial = {6'd0, byte_i[3:0]};
        state_o.phase   = PH_TWO;
      end else begin
        state_o.err = ERR_MALFORMED;
      end
    end else if (!is_cont) begin
      state_o.err     = ERR_MALFORMED;
      state_o.phase   = PH_LEAD;
      state_o.partial = '0;
    end else if (state_i.phase == PH_TWO) begin
      state_o.partial = cp[PartW-1:0];
      state_o.phase   = PH_ONE;
    end else begin
      state_o.phase   = PH_LEAD;
      state_o.partial = '0;
      if (cp >= SurrLo && cp <= SurrHi) begin
        state_o.err = ERR_SURROGATE;
      end else begin
        result_o.valid      = 1'b1;
        result_o.unit_valid = 1'b1;
        result_o.code_unit  = cp;
        state_o.units       = state_i.units + CountW'(1);
      end
    end
  end

endmodule

@@ hdl/utf8_to_utf16_bmp_decoder_unit.sv @@
// Top level of the UTF-8 to UTF-16 (BMP) stream decoder.
// Depends on u8u16_pkg and u8u16_step.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------
//   input   | in        | in_valid_i / in_stall_o   | byte_in_i
//   output  | out       | out_valid_o / out_stall_i | code_unit_o, unit_valid_o,
//           |           |                           | done_res_o, status_o, unit_count_o
//   config  | in        | cfg_valid_i / cfg_ready_o | cfg_unit_limit_i
//
// One byte per cycle sustained while the output does not stall, with no gap between
// back-to-back bytes. A byte waits in the input register, where the step logic
// decodes it, and its result is loaded into the result register as it advances.
// The string state advances as the byte leaves the input register. Reset clears
// the string state and loads the unit limit with 1024. A stalled output holds
// the result register; input stalls only while the input register is also full.
module utf8_to_utf16_bmp_decoder_unit
  import u8u16_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ByteW-1:0]  byte_in_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [UnitW-1:0]  code_unit_o,
  output logic              unit_valid_o,
  output logic              done_res_o,
  output logic [1:0]        status_o,
  output logic [CountW-1:0] unit_count_o,
  // configuration write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_unit_limit_i
);

  logic [CountW-1:0] unit_limit_q;

  logic              in_full_q;
  logic [ByteW-1:0]  byte_q;

  dec_state_t        state_q, state_d;
  dec_result_t       step_res;

  logic              res_valid_q;
  dec_result_t       res_q;

  logic              out_free;
  logic              advance;
  logic              in_xfer;

  // Result register can take a new entry when empty or being drained.
  assign out_free   = !res_valid_q || !out_stall_i;
  assign advance    = in_full_q && out_free;
  assign in_stall_o = in_full_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // The user must write registers only while idle; unenforced, ready is tied high.
  assign cfg_ready_o = 1'b1;

  u8u16_step u_step (
    .byte_i       (byte_q),
    .state_i      (state_q),
    .unit_limit_i (unit_limit_q),
    .state_o      (state_d),
    .result_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_limit_q <= MaxUnitsReset;
      in_full_q    <= 1'b0;
      res_valid_q  <= 1'b0;
      state_q      <= '{phase: PH_LEAD, partial: '0, units: '0, err: ERR_NONE};
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unit_limit_q <= cfg_unit_limit_i;
      end
      // Input register: refill on transfer, empty when the byte advances.
      if (in_xfer) begin
        in_full_q <= 1'b1;
      end else if (advance) begin
        in_full_q <= 1'b0;
      end
      // Advance the string state with each decoded byte.
      if (advance) begin
        state_q <= state_d;
      end
      // Result register: load a result, or drop the drained one.
      if (advance) begin
        res_valid_q <= step_res.valid;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= byte_in_i;
    end
    if (advance && step_res.valid) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign code_unit_o  = res_q.code_unit;
  assign unit_valid_o = res_q.unit_valid;
  assign done_res_o   = res_q.done_res;
  assign status_o     = res_q.status;
  assign unit_count_o = res_q.unit_count;

endmodule

@@ hdl/u8u16_checker.sv @@
// Port-level checker for the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends on u8u16_pkg.
module u8u16_checker
  import u8u16_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [UnitW-1:0]  code_unit_o,
  input logic              unit_valid_o,
  input logic              done_res_o,
  input logic [1:0]        status_o,
  input logic [CountW-1:0] unit_count_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_unit_o)
      && $stable(unit_count_o) && $stable(status_o) && $stable(done_res_o))
    else $error("stalled result changed");

  // Every result is either a unit or an end-of-string report, never both.
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (unit_valid_o ^ done_res_o))
    else $error("result kind flags inconsistent");

  // A unit result carries no status or count; an end report carries no unit.
  a_unit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unit_valid_o |-> status_o == ERR_NONE && unit_count_o == '0)
    else $error("unit result has end fields set");

  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> code_unit_o == '0)
    else $error("end result has a code unit");

  // Input only backs up when the output does.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

endmodule

bind utf8_to_utf16_bmp_decoder_unit u8u16_checker u_u8u16_checker (.*);

@@ tb/sv/utf8_to_utf16_bmp_decoder_unit_test.sv @@
// Self-checking test of the UTF-8 to UTF-16 (BMP) stream decoder unit.
// Depends on u8u16_pkg and utf8_to_utf16_bmp_decoder_unit; runs a directed vector
// list, then random strings, checked against typed rows or a built-in decoder.
module utf8_to_utf16_bmp_decoder_unit_test;
  import u8u16_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseBytes = 135;

  // One result as it appears on the output ports.
  typedef struct packed {
    logic [UnitW-1:0]  code_unit;
    logic              unit_valid;
    logic              done_res;
    err_e              status;
    logic [CountW-1:0] unit_count;
  } unit_res_t;

  // One row of the directed list: a byte, or a write of the unit limit.
  typedef struct {
    bit               is_cfg;
    logic [CountW-1:0] cfg_val;
    logic [ByteW-1:0] b;
    bit               typed;
    bit               has;
    unit_res_t        want;
  } vec_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall_o;
  logic [ByteW-1:0]  byte_in = '0;
  logic              out_valid_o;
  logic              out_stall = 1'b0;
  logic [UnitW-1:0]  code_unit_o;
  logic              unit_valid_o;
  logic              done_res_o;
  logic [1:0]        status_o;
  logic [CountW-1:0] unit_count_o;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_unit_limit = '0;

  // Decoder state mirrored on the test side, plus the configured limit.
  phase_e            dec_phase = PH_LEAD;
  logic [PartW-1:0]  dec_part = '0;
  logic [CountW-1:0] dec_units = '0;
  err_e              dec_err = ERR_NONE;
  logic [CountW-1:0] lim_units = MaxUnitsReset;

  unit_res_t decoded_q[$];   // results still owed by the block, oldest first
  vec_t      vectors[$];
  bit        idle_on = 1'b1; // allow random gaps and stalls
  int        sent = 0;
  int        mismatches = 0;
  int        cycles = 0;
  int        stall_left = 0;

  always #6 clk = ~clk;

  utf8_to_utf16_bmp_decoder_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .byte_in_i       (byte_in),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .code_unit_o     (code_unit_o),
    .unit_valid_o    (unit_valid_o),
    .done_res_o      (done_res_o),
    .status_o        (status_o),
    .unit_count_o    (unit_count_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_unit_limit_i(cfg_unit_limit)
  );

  // Advance the mirrored decoder by one byte; hit is set when a result is due.
  task automatic decode_byte(input logic [ByteW-1:0] b, output bit hit,
                             output unit_res_t r);
    logic [UnitW-1:0] cp;
    hit = 1'b0;
    r   = '0;
    cp  = '0;
    if (b == 8'h00) begin
      // Terminator: a sequence cut short counts as malformed.
      if (dec_err == ERR_NONE && dec_phase != PH_LEAD) dec_err = ERR_MALFORMED;
      hit          = 1'b1;
      r.done_res   = 1'b1;
      r.status     = dec_err;
      r.unit_count = dec_units;
      dec_phase    = PH_LEAD;
      dec_part     = '0;
      dec_units    = '0;
      dec_err      = ERR_NONE;
    end else if (dec_err != ERR_NONE) begin
      // Swallow everything up to the terminator.
    end else if (dec_phase == PH_LEAD) begin
      // The limit check comes first and beats a bad lead.
      if (dec_units >= lim_units) begin
        dec_err = ERR_OVERFLOW;
      end else if (!b[7]) begin
        hit         = 1'b1;
        r.code_unit = {8'h00, b};
        r.unit_valid = 1'b1;
        dec_units   = dec_units + 16'd1;
      end else if (b[7:5] == 3'b110) begin
        dec_part  = {5'b0, b[4:0]};
        dec_phase = PH_ONE;
      end else if (b[7:4] == 4'b1110) begin
        dec_part  = {6'b0, b[3:0]};
        dec_phase = PH_TWO;
      end else begin
        dec_err = ERR_MALFORMED;
      end
    end else if (b[7:6] != 2'b10) begin
      dec_err   = ERR_MALFORMED;
      dec_phase = PH_LEAD;
      dec_part  = '0;
    end else if (dec_phase == PH_TWO) begin
      dec_part  = {dec_part[3:0], b[5:0]};
      dec_phase = PH_ONE;
    end else begin
      cp        = {dec_part, b[5:0]};
      dec_phase = PH_LEAD;
      dec_part  = '0;
      if (cp >= SurrLo && cp <= SurrHi) begin
        dec_err = ERR_SURROGATE;
      end else begin
        hit          = 1'b1;
        r.code_unit  = cp;
        r.unit_valid = 1'b1;
        dec_units    = dec_units + 16'd1;
      end
    end
  endtask

  // Offer one byte, maybe after a short gap, and hold it until the transfer.
  // A typed row replaces whatever the mirrored decoder predicts.
  task automatic push_byte(input logic [ByteW-1:0] b, input bit typed,
                           input bit has_t, input unit_res_t want_t);
    bit        has;
    unit_res_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(posedge clk); while (in_stall_o);
    sent++;
    decode_byte(b, has, want);
    if (typed) begin
      has  = has_t;
      want = want_t;
    end
    if (has) decoded_q.push_back(want);
  endtask

  // Drain the block, then write the unit limit.
  task automatic write_limit(input logic [CountW-1:0] v);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    // A trailing byte may still sit in the pipe without a result.
    repeat (4) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_unit_limit <= v;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    lim_units = v;
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // Build one random string, mostly well-formed characters, and send it.
  task automatic send_string();
    logic [ByteW-1:0] s[$];
    int n;
    int k;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    repeat (n) begin
      k = $urandom_range(0, 19);
      if (k < 6 || k == 17) begin
        s.push_back(8'($urandom_range(1, 127)));
      end else if (k < 10 || k == 18) begin
        s.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        s.push_back(cont_byte());
      end else if (k < 14 || k == 19) begin
        s.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        s.push_back(cont_byte());
        s.push_back(cont_byte());
      end else if (k == 14) begin
        // Encoded surrogate.
        s.push_back(8'hED);
        s.push_back(8'($urandom_range(8'hA0, 8'hBF)));
        s.push_back(cont_byte());
      end else if (k == 15) begin
        // Sequence cut short: lead with one continuation too few.
        if ($urandom_range(0, 1) == 1) begin
          s.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        end else begin
          s.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          s.push_back(cont_byte());
        end
      end else begin
        s.push_back(8'($urandom_range(1, 255)));
      end
    end
    s.push_back(8'h00);
    foreach (s[i]) push_byte(s[i], 1'b0, 1'b0, '0);
  endtask

  // Row builders for the directed list.
  function automatic vec_t vp(input logic [ByteW-1:0] b);
    vec_t v;
    v = '{is_cfg: 1'b0, cfg_val: '0, b: b, typed: 1'b0, has: 1'b0, want: '0};
    return v;
  endfunction

  function automatic vec_t vq(input logic [ByteW-1:0] b);
    vec_t v;
    v = vp(b);
    v.typed = 1'b1;
    return v;
  endfunction

  function automatic vec_t vu(input logic [ByteW-1:0] b, input logic [UnitW-1:0] cu);
    vec_t v;
    v = vq(b);
    v.has  = 1'b1;
    v.want = '{code_unit: cu, unit_valid: 1'b1, done_res: 1'b0,
               status: ERR_NONE, unit_count: '0};
    return v;
  endfunction

  function automatic vec_t vd(input err_e st, input logic [CountW-1:0] cnt);
    vec_t v;
    v = vq(8'h00);
    v.has  = 1'b1;
    v.want = '{code_unit: '0, unit_valid: 1'b0, done_res: 1'b1,
               status: st, unit_count: cnt};
    return v;
  endfunction

  function automatic vec_t vc(input logic [CountW-1:0] val);
    vec_t v;
    v = vp(8'h00);
    v.is_cfg  = 1'b1;
    v.cfg_val = val;
    return v;
  endfunction

  function automatic string show(input unit_res_t r);
    return $sformatf("unit=%h uv=%0d done=%0d status=%0d count=%0d",
                     r.code_unit, r.unit_valid, r.done_res, r.status, r.unit_count);
  endfunction

  // Output stall: random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4);
    end
    out_stall <= (stall_left > 0);
  end

  // Compare every output transfer with the oldest owed result.
  always @(posedge clk) begin
    unit_res_t got;
    unit_res_t want;
    bit        stray;
    bit        bad;
    if (rst_n && out_valid_o && !out_stall) begin
      got   = '{code_unit: code_unit_o, unit_valid: unit_valid_o, done_res: done_res_o,
                status: err_e'(status_o), unit_count: unit_count_o};
      stray = (decoded_q.size() == 0);
      want  = '0;
      bad   = stray;
      if (!stray) begin
        want = decoded_q.pop_front();
        bad  = (got !== want);
      end
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at cycle %0d: expected %s, got %s", cycles,
                   stray ? "no result" : show(want), show(got));
      end
    end
  end

  // Run limit.
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("utf8_to_utf16_bmp_decoder_unit_test: done, errors");
    $finish;
  end

  initial begin
    logic [CountW-1:0] lim;
    int                goal;

    // Directed rows, starting from the reset limit of 1024.
    vectors = {
      vd(ERR_NONE, 16'd0),            // empty string
      vu(8'h01, 16'h0001),            // lowest nonzero single byte
      vu(8'h7F, 16'h007F),            // highest single byte
      vp(8'hC2), vp(8'h80),           // lowest proper two-byte form
      vp(8'hC0), vu(8'h80, 16'h0000), // overlong two-byte zero is let through
      vp(8'hEF), vp(8'hBF), vu(8'hBF, 16'hFFFF), // top of the plane
      vp(8'h00),
      vp(8'hED), vp(8'hA0), vq(8'h80),           // lowest surrogate
      vq(8'h41), vd(ERR_SURROGATE, 16'd0),       // swallowed after the error
      vq(8'h80), vd(ERR_MALFORMED, 16'd0),       // continuation as a lead
      vq(8'hF0), vd(ERR_MALFORMED, 16'd0),       // four-byte lead
      vp(8'hC3), vq(8'h41), vd(ERR_MALFORMED, 16'd0), // bad continuation
      vp(8'hE1), vd(ERR_MALFORMED, 16'd0),       // terminator mid-sequence
      vc(16'd1),
      vu(8'h41, 16'h0041), vq(8'hFF),            // limit reached beats bad lead
      vd(ERR_OVERFLOW, 16'd1)
    };

    // Hold reset, then release it on a rising edge.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      if (vectors[i].is_cfg) write_limit(vectors[i].cfg_val);
      else push_byte(vectors[i].b, vectors[i].typed, vectors[i].has, vectors[i].want);
    end

    // Random strings under a series of limits; phases 2, 6 and 7 run without gaps.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: lim = 16'hFFFF;
        1: lim = 16'd1;
        2: lim = 16'($urandom_range(2, 24));
        3: lim = 16'($urandom_range(1, 65535));
        4: lim = 16'd3;
        5: lim = 16'($urandom_range(2, 24));
        6: lim = MaxUnitsReset;
        default: lim = 16'hFFFF;
      endcase
      write_limit(lim);
      idle_on <= (ph != 2 && ph < 6);
      goal = sent + PhaseBytes;
      while (sent < goal) send_string();
    end

    // Drop valid, drain, then leave room for anything stray to show up.
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0)
      $display("utf8_to_utf16_bmp_decoder_unit_test: done, clean");
    else
      $display("utf8_to_utf16_bmp_decoder_unit_test: done, errors");
    $finish;
  end

endmodule
